/* hw/rtl/rc5d_pkg.sv */
// Shared types and constants for the RC5 run-length decoder.
package rc5d_pkg;

    localparam int RUN_LEN_W   = 7;
    localparam int HB_CFG_W    = 6;
    localparam int HALF_W      = 29;
    localparam int CNT_W       = 5;
    localparam int RUNS_W      = 3;
    localparam int CODE_BITS   = 14;
    localparam int ADDR_W      = 5;
    localparam int CMD_W       = 6;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [CNT_W-1:0]  FULL_HALF   = 5'd28;
    localparam logic [CNT_W-1:0]  FILL_HALF   = 5'd27;
    localparam logic [RUNS_W-1:0] RUNS_SAT    = 3'd4;
    localparam logic [HALF_W-1:0] STORE_RESET = 29'd1;

    // Configuration register indexes
    localparam logic CFG_HALF_BIT_MIN = 1'b0;
    localparam logic CFG_HALF_BIT_MAX = 1'b1;

    // Run classes
    localparam logic [1:0] KIND_FINISH = 2'd0;
    localparam logic [1:0] KIND_ONE    = 2'd1;
    localparam logic [1:0] KIND_TWO    = 2'd2;
    localparam logic [1:0] KIND_FAIL   = 2'd3;

    typedef struct packed {
        logic                 run_level;
        logic [RUN_LEN_W-1:0] run_length;
        logic                 last_run;
    } run_in_t;

    typedef struct packed {
        logic                 code_valid;
        logic [CODE_BITS-1:0] raw_code;
        logic                 toggle_bit;
        logic [ADDR_W-1:0]    system_address;
        logic [CMD_W-1:0]     command_value;
    } code_out_t;

    typedef struct packed {
        logic       level;
        logic [1:0] kind;
        logic       last;
    } run_item_t;

endpackage

/* hw/rtl/rc5d_front.sv */
// Front end: configuration registers and run classification.
module rc5d_front (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic                     cfg_index,
    input  logic [5:0]               cfg_data,
    input  rc5d_pkg::run_in_t        run_data,
    output rc5d_pkg::run_item_t      item
);
    import rc5d_pkg::*;

    logic [HB_CFG_W-1:0]  hb_min_reg;
    logic [HB_CFG_W-1:0]  hb_max_reg;
    logic [RUN_LEN_W-1:0] min_ext;
    logic [RUN_LEN_W-1:0] max_ext;
    logic [RUN_LEN_W-1:0] dbl;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hb_min_reg <= 6'd36;
            hb_max_reg <= 6'd52;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_HALF_BIT_MIN: hb_min_reg <= cfg_data;
                CFG_HALF_BIT_MAX: hb_max_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign min_ext = {1'b0, hb_min_reg};
    assign max_ext = {1'b0, hb_max_reg};
    assign dbl     = {hb_max_reg, 1'b0};

    always_comb
    begin
        item.level = run_data.run_level;
        item.last  = run_data.last_run;
        if (run_data.run_level && (run_data.run_length > dbl))
            item.kind = KIND_FINISH;
        else if ((run_data.run_length >= min_ext) && (run_data.run_length <= max_ext))
            item.kind = KIND_ONE;
        else if ((run_data.run_length > max_ext) && (run_data.run_length <= dbl))
            item.kind = KIND_TWO;
        else
            item.kind = KIND_FAIL;
    end

endmodule

/* hw/rtl/rc5d_queue.sv */
// Short queue of classified runs between front and back.
module rc5d_queue #(
    parameter int DEPTH = rc5d_pkg::QUEUE_DEPTH
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_valid,
    input  rc5d_pkg::run_item_t  wr_item,
    output logic                 full,
    input  logic                 rd_pop,
    output logic                 rd_valid,
    output rc5d_pkg::run_item_t  rd_item
);
    import rc5d_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_QW = $clog2(DEPTH + 1);

    run_item_t          entry_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_QW-1:0]  count_reg;
    logic               push;
    logic               pop;

    assign full     = (count_reg == CNT_QW'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_item  = entry_reg[rd_ptr_reg];
    assign push     = wr_valid && !full;
    assign pop      = rd_pop && rd_valid;

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= wr_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

/* hw/rtl/rc5d_back.sv */
// Back end: half-bit frame state, code decode and result register.
module rc5d_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    input  rc5d_pkg::run_item_t  q_item,
    output logic                 q_pop,
    output logic                 res_valid,
    input  logic                 res_stall,
    output rc5d_pkg::code_out_t  res_data
);
    import rc5d_pkg::*;

    logic [HALF_W-1:0]    store_reg, store_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 fin_reg, fin_next;
    logic                 fail_reg, fail_next;
    logic [RUNS_W-1:0]    runs_reg, runs_next;
    logic                 out_valid_reg;
    code_out_t            out_reg;
    code_out_t            result;

    logic [HALF_W-1:0]    store_a, store_f;
    logic [CNT_W-1:0]     cnt_a, cnt_f;
    logic                 fin_a, fail_a, ok, bad;
    logic [CODE_BITS-1:0] code;
    logic [1:0]           pair;

    // a last run needs room in the result register
    assign q_pop = q_valid && (!q_item.last || !out_valid_reg || !res_stall);

    always_comb
    begin
        store_a = store_reg;
        cnt_a   = cnt_reg;
        fin_a   = fin_reg;
        fail_a  = fail_reg;
        runs_next = (runs_reg < RUNS_SAT) ? runs_reg + 3'd1 : runs_reg;

        if (!fin_reg && !fail_reg)
        begin
            unique case (q_item.kind)
                KIND_FINISH: fin_a = 1'b1;
                KIND_ONE:
                begin
                    store_a = store_a | (HALF_W'(q_item.level) << cnt_reg);
                    cnt_a   = cnt_reg + 5'd1;
                end
                KIND_TWO:
                begin
                    store_a = store_a | (HALF_W'(q_item.level) << cnt_reg)
                                      | (HALF_W'(q_item.level) << (cnt_reg + 5'd1));
                    cnt_a   = cnt_reg + 5'd2;
                end
                KIND_FAIL: fail_a = 1'b1;
                default: fail_a = 1'b1;
            endcase
            if ((q_item.kind == KIND_ONE) || (q_item.kind == KIND_TWO))
            begin
                if (cnt_a >= FULL_HALF)
                    fin_a = 1'b1;
                else if ((cnt_a == FILL_HALF) && !q_item.level)
                begin
                    store_a[FILL_HALF] = 1'b1;
                    cnt_a = FULL_HALF;
                    fin_a = 1'b1;
                end
            end
        end

        // result for a last run
        store_f = store_a;
        cnt_f   = cnt_a;
        ok      = (runs_next >= RUNS_SAT) && !fail_a;
        if (ok && (cnt_f == FILL_HALF))
        begin
            store_f[FILL_HALF] = 1'b1;
            cnt_f = FULL_HALF;
        end
        code = '0;
        bad  = 1'b0;
        for (int k = 0; k < CODE_BITS; k++)
        begin
            pair = store_f[2*k +: 2];
            if (pair == 2'b01)
                code[CODE_BITS-1-k] = 1'b1;
            else if (pair != 2'b10)
                bad = 1'b1;
        end
        result.code_valid = ok && (cnt_f == FULL_HALF) && !bad;
        if (!result.code_valid)
            code = '0;
        result.raw_code       = code;
        result.toggle_bit     = code[11];
        result.system_address = code[10:6];
        result.command_value  = code[5:0];

        if (q_item.last)
        begin
            store_next = STORE_RESET;
            cnt_next   = 5'd1;
            fin_next   = 1'b0;
            fail_next  = 1'b0;
            runs_next  = '0;
        end
        else
        begin
            store_next = store_a;
            cnt_next   = cnt_a;
            fin_next   = fin_a;
            fail_next  = fail_a;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            store_reg     <= STORE_RESET;
            cnt_reg       <= 5'd1;
            fin_reg       <= 1'b0;
            fail_reg      <= 1'b0;
            runs_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                store_reg <= store_next;
                cnt_reg   <= cnt_next;
                fin_reg   <= fin_next;
                fail_reg  <= fail_next;
                runs_reg  <= runs_next;
            end
            if (q_pop && q_item.last)
                out_valid_reg <= 1'b1;
            else if (!res_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop && q_item.last)
            out_reg <= result;
    end

    assign res_valid = out_valid_reg;
    assign res_data  = out_reg;

endmodule

/* hw/rtl/rc5_run_length_decoder.sv */
// Top level of the RC5 run-length decoder.
// Throughput: one run beat per cycle, sustained, while the result side keeps up.
// Result path: a last run passes through the run queue, and its result beat
//   is held in the result register.
// Reset (rst_n, async, active low): frame state cleared, queue empty,
//   half_bit_min = 36, half_bit_max = 52.
module rc5_run_length_decoder #(
    parameter int QUEUE_DEPTH = rc5d_pkg::QUEUE_DEPTH
) (
    input  logic                 clk,
    input  logic                 rst_n,
    // run channel
    input  logic                 run_valid,
    output logic                 run_stall,
    input  rc5d_pkg::run_in_t    run_data,
    // result channel
    output logic                 res_valid,
    input  logic                 res_stall,
    output rc5d_pkg::code_out_t  res_data,
    // configuration write channel
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic                 cfg_index,
    input  logic [5:0]           cfg_data
);
    import rc5d_pkg::*;

    run_item_t cls_item;
    run_item_t q_item;
    logic      q_full;
    logic      q_valid;
    logic      q_pop;

    // Front: classify each run against the half-bit window (one, two,
    // end-of-frame gap, or fail) in the same cycle it is accepted.
    rc5d_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .run_data  (run_data),
        .item      (cls_item)
    );

    // The front stalls only when the queue is full.
    assign run_stall = q_full;

    rc5d_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (run_valid),
        .wr_item  (cls_item),
        .full     (q_full),
        .rd_pop   (q_pop),
        .rd_valid (q_valid),
        .rd_item  (q_item)
    );

    // Back: one classified run per cycle updates the half-bit store, but a last run
    // waits while an unaccepted result is held; it decodes the frame into the
    // result register and clears state. Non-last runs never wait on the result side.
    rc5d_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data)
    );

endmodule

/* test/tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the RC5 run-length decoder: random run traffic, scoreboard.
module tb;
    import rc5d_pkg::*;

    localparam int CLK_HALF    = 4;
    localparam int CYCLE_LIMIT = 400000;  // watchdog limit on the whole simulation
    localparam int DRAIN       = 6;       // idle margin at the end of wait_for_idle
    localparam int HOLD_CYCLES = 80;      // long result hold-off, fills the run queue
    localparam int SEG_RUNS    = 225;     // run beats per random segment
    localparam int NUM_SEGS    = 6;

    // How a well-formed frame ends on the wire
    typedef enum int {
        STYLE_ANY,       // pick one of the others at random
        STYLE_GAP_DROP,  // trailing high half merged into the idle gap
        STYLE_OPEN,      // every run sent, last flag on the final run, no gap
        STYLE_GAP_FULL   // every run sent, then a gap, maybe junk after it
    } frame_style_t;

    // Ways a frame gets broken
    typedef enum int {
        MUT_LENGTH,  // one run gets a random duration
        MUT_DROP,    // one run vanishes
        MUT_CUT      // buffer ends early
    } mutation_t;

    // Threshold settings per random segment, extremes and an inverted pair included
    int seg_min [NUM_SEGS] = '{30, 1, 63, 12, 63, 1};
    int seg_max [NUM_SEGS] = '{45, 63, 1, 20, 63, 1};

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       run_valid = 1'b0;
    logic       run_stall;
    run_in_t    run_data  = '0;
    logic       res_valid;
    logic       res_stall = 1'b0;
    code_out_t  res_data;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic       cfg_index = CFG_HALF_BIT_MIN;
    logic [5:0] cfg_data  = '0;

    rc5_run_length_decoder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .run_valid (run_valid),
        .run_stall (run_stall),
        .run_data  (run_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #CLK_HALF clk = ~clk;

    // ------------------------------------------------------------------
    // Decoder mirror: thresholds and frame state, advanced per run beat
    // ------------------------------------------------------------------
    logic [HB_CFG_W-1:0] cfg_min = 6'd36;
    logic [HB_CFG_W-1:0] cfg_max = 6'd52;

    logic [HALF_W-1:0]   hb_store = STORE_RESET;  // half-bit i in bit i
    logic [CNT_W-1:0]    hb_count = 5'd1;         // leading 1 half-bit is assumed
    bit                  hb_done  = 1'b0;         // frame ended, later runs ignored
    bit                  hb_bad   = 1'b0;         // frame broken, later runs ignored
    logic [RUNS_W-1:0]   runs_cnt = '0;           // saturating run count

    code_out_t expected_codes[$];
    run_in_t   run_queue[$];

    int runs_queued   = 0;
    int runs_accepted = 0;
    int segment_runs  = 0;
    int codes_checked = 0;
    int valid_codes   = 0;
    int cfg_writes    = 0;
    int errors        = 0;
    int cycles        = 0;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    bit hold_armed    = 1'b0;
    bit hold_used;
    int hold_cnt;

    function automatic void frame_clear();
        hb_store = STORE_RESET;
        hb_count = 5'd1;
        hb_done  = 1'b0;
        hb_bad   = 1'b0;
        runs_cnt = '0;
    endfunction

    function automatic void add_half(logic lvl);
        if (hb_count < HALF_W)
            hb_store[hb_count] = hb_store[hb_count] | lvl;
        hb_count++;
    endfunction

    // One accepted run beat; on the last run of a buffer this queues one code.
    function automatic void predict_run(run_in_t r);
        int unsigned          dbl;
        int unsigned          len;
        bit                   took;
        bit                   ok;
        logic [CODE_BITS-1:0] code;
        code_out_t            res;
        int                   k;
        dbl = 2 * cfg_max;
        len = r.run_length;
        if (runs_cnt < RUNS_SAT)
            runs_cnt++;
        if (!hb_done && !hb_bad)
        begin
            took = 1'b1;
            // order matters: a long high gap wins over any half-bit match
            if (r.run_level && len > dbl)
            begin
                hb_done = 1'b1;
                took    = 1'b0;
            end
            else if (len >= cfg_min && len <= cfg_max)
                add_half(r.run_level);
            else if (len > cfg_max && len <= dbl)
            begin
                add_half(r.run_level);
                add_half(r.run_level);
            end
            else
            begin
                hb_bad = 1'b1;
                took   = 1'b0;
            end
            if (took)
            begin
                if (hb_count >= FULL_HALF)
                    hb_done = 1'b1;
                else if (hb_count == FILL_HALF && !r.run_level)
                begin
                    // final high half hides in the idle line
                    add_half(1'b1);
                    hb_done = 1'b1;
                end
            end
        end
        if (r.last_run)
        begin
            ok   = 1'b0;
            code = '0;
            if (runs_cnt >= RUNS_SAT && !hb_bad)
            begin
                if (hb_count == FILL_HALF)
                    add_half(1'b1);
                if (hb_count == FULL_HALF)
                begin
                    ok = 1'b1;
                    // 1 then 0 is a code 1, 0 then 1 a code 0, else broken
                    for (k = 0; k < CODE_BITS; k++)
                        if (ok)
                        begin
                            if (hb_store[2*k +: 2] == 2'b01)
                                code[CODE_BITS-1-k] = 1'b1;
                            else if (hb_store[2*k +: 2] != 2'b10)
                                ok = 1'b0;
                        end
                    if (!ok)
                        code = '0;
                end
            end
            res.code_valid     = ok;
            res.raw_code       = code;
            res.toggle_bit     = code[11];
            res.system_address = code[10:6];
            res.command_value  = code[5:0];
            expected_codes.push_back(res);
            frame_clear();
        end
    endfunction

    // ------------------------------------------------------------------
    // Run driver: one beat per queued item, random gaps, holds while stalled
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_valid <= 1'b0;
            run_data  <= '0;
        end
        else
        begin
            if (run_valid && !run_stall)
            begin
                predict_run(run_data);
                runs_accepted <= runs_accepted + 1;
            end
            // a stalled beat stays on the bus untouched
            if (!run_valid || !run_stall)
            begin
                if (run_queue.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    run_valid <= 1'b1;
                    run_data  <= run_queue.pop_front();
                end
                else
                    run_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: scoreboard check plus the receiver's stall pattern
    // ------------------------------------------------------------------
    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : result_monitor
        code_out_t want;
        int        hold_next;
        if (!rst_n)
        begin
            res_stall <= 1'b0;
            hold_cnt  <= 0;
            hold_used <= 1'b0;
        end
        else
        begin
            if (res_valid && !res_stall)
            begin
                if (expected_codes.size() == 0)
                begin
                    $display("%0t ns: unexpected code beat, expected none, actual 0x%0h",
                             $time, res_data);
                    errors++;
                end
                else
                begin
                    want = expected_codes.pop_front();
                    check_field("code_valid", want.code_valid, res_data.code_valid);
                    check_field("raw_code", want.raw_code, res_data.raw_code);
                    check_field("toggle_bit", want.toggle_bit, res_data.toggle_bit);
                    check_field("system_address", want.system_address,
                                res_data.system_address);
                    check_field("command_value", want.command_value,
                                res_data.command_value);
                    codes_checked++;
                    if (want.code_valid)
                        valid_codes++;
                end
            end
            // one long hold-off once a code is waiting, so the run side backs up
            if (hold_cnt != 0)
                hold_next = hold_cnt - 1;
            else if (hold_armed && !hold_used && res_valid)
            begin
                hold_next = HOLD_CYCLES;
                hold_used <= 1'b1;
            end
            else
                hold_next = 0;
            hold_cnt  <= hold_next;
            res_stall <= (hold_next != 0) || ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", CYCLE_LIMIT);
            $display("Verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_run(input logic lvl, input logic [RUN_LEN_W-1:0] len,
                            input logic last);
        run_in_t r;
        r.run_level  = lvl;
        r.run_length = len;
        r.last_run   = last;
        run_queue.push_back(r);
        runs_queued++;
        segment_runs++;
    endtask

    // Duration for a run of n half-bits under the current thresholds
    function automatic logic [RUN_LEN_W-1:0] pick_len(input int n, input bit extreme);
        int lo;
        int hi;
        lo = (n == 1) ? cfg_min : cfg_max + 1;
        hi = (n == 1) ? cfg_max : 2 * cfg_max;
        if (lo > hi)
            return RUN_LEN_W'($urandom_range(127));  // no legal value, anything goes
        if (extreme)
            return RUN_LEN_W'($urandom_range(1) ? hi : lo);
        return RUN_LEN_W'($urandom_range(hi, lo));
    endfunction

    // Encode a 14-bit code as Manchester runs, optionally break it, queue it.
    task automatic queue_frame(input logic [CODE_BITS-1:0] code, input bit extreme,
                               input bit broken, input frame_style_t style);
        logic [2*CODE_BITS-1:0] half;
        run_in_t                runs[$];
        run_in_t                r;
        int                     i;
        int                     n;
        int                     idx;
        int                     extra;
        int                     lo;
        for (i = 0; i < CODE_BITS; i++)
        begin
            half[2*i]   = code[CODE_BITS-1-i];
            half[2*i+1] = ~code[CODE_BITS-1-i];
        end
        // half-bit 0 is assumed by the decoder, the wire starts at half-bit 1
        i = 1;
        while (i < 2 * CODE_BITS)
        begin
            n = (i < 2 * CODE_BITS - 1 && half[i+1] == half[i]) ? 2 : 1;
            r.run_level  = half[i];
            r.run_length = pick_len(n, extreme);
            r.last_run   = 1'b0;
            runs.push_back(r);
            i += n;
        end
        if (style == STYLE_ANY)
            style = frame_style_t'($urandom_range(STYLE_GAP_FULL, STYLE_GAP_DROP));
        if (style == STYLE_GAP_DROP && runs[runs.size()-1].run_level)
            runs.delete(runs.size() - 1);
        if (style != STYLE_OPEN)
        begin
            lo = 2 * cfg_max + 1;
            r.run_level  = 1'b1;
            r.run_length = extreme ? RUN_LEN_W'($urandom_range(1) ? 127 : lo)
                                   : RUN_LEN_W'($urandom_range(127, lo));
            r.last_run   = 1'b0;
            runs.push_back(r);
        end
        if (broken)
        begin
            idx = $urandom_range(runs.size() - 1);
            case (mutation_t'($urandom_range(MUT_CUT, MUT_LENGTH)))
                MUT_LENGTH:
                begin
                    r            = runs[idx];
                    r.run_length = RUN_LEN_W'($urandom_range(127));
                    runs[idx]    = r;
                end
                MUT_DROP:
                    runs.delete(idx);
                default:
                    while (runs.size() > idx + 1)
                        runs.delete(runs.size() - 1);
            endcase
        end
        segment_runs += runs.size();
        // junk after the gap is ignored by the decoder, not counted
        extra = (style == STYLE_GAP_FULL && $urandom_range(3) == 0) ? $urandom_range(3, 1) : 0;
        repeat (extra)
        begin
            r.run_level  = 1'($urandom_range(1));
            r.run_length = RUN_LEN_W'($urandom_range(127));
            r.last_run   = 1'b0;
            runs.push_back(r);
        end
        r          = runs[runs.size()-1];
        r.last_run = 1'b1;
        runs[runs.size()-1] = r;
        foreach (runs[j])
            run_queue.push_back(runs[j]);
        runs_queued += runs.size();
    endtask

    task automatic write_reg(input logic idx, input logic [HB_CFG_W-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_HALF_BIT_MIN)
            cfg_min = value;
        else
            cfg_max = value;
        cfg_writes++;
    endtask

    // All beats sent, all codes back, then a DRAIN wait for runs that give no code
    task automatic wait_for_idle();
        while (runs_accepted != runs_queued || expected_codes.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        logic [CODE_BITS-1:0] code;
        int                   seg;
        int                   n;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed, reset thresholds 36/52.
        // Buffer of three runs: too short to decode.
        push_run(1'b0, 7'd40, 1'b0);
        push_run(1'b1, 7'd40, 1'b0);
        push_run(1'b1, 7'd127, 1'b1);
        // Long low run breaks the frame at once.
        push_run(1'b0, 7'd127, 1'b0);
        push_run(1'b1, 7'd36, 1'b0);
        push_run(1'b0, 7'd52, 1'b0);
        push_run(1'b1, 7'd40, 1'b1);
        // Alternating code: all double runs at the edges, trailing 1 filled in.
        queue_frame(14'h2AAA, 1'b1, 1'b0, STYLE_GAP_DROP);
        // Gap right away ends the frame; zero-length run after it is ignored.
        push_run(1'b1, 7'd105, 1'b0);
        push_run(1'b0, 7'd0, 1'b0);
        push_run(1'b0, 7'd40, 1'b0);
        push_run(1'b1, 7'd50, 1'b1);

        for (seg = 0; seg < NUM_SEGS; seg++)
        begin
            wait_for_idle();
            write_reg(CFG_HALF_BIT_MIN, HB_CFG_W'(seg_min[seg]));
            write_reg(CFG_HALF_BIT_MAX, HB_CFG_W'(seg_max[seg]));
            // receiver-heavy idling, then sender-heavy, then none at all
            case (seg / 2)
                0:
                begin
                    send_idle_pct = 29;
                    recv_idle_pct = 84;
                end
                1:
                begin
                    send_idle_pct = 84;
                    recv_idle_pct = 29;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            if (seg == 4)
                hold_armed = 1'b1;
            segment_runs = 0;
            while (segment_runs < SEG_RUNS)
            begin
                if ($urandom_range(9) < 8)
                begin
                    code = CODE_BITS'($urandom_range(16383));
                    // real frames start with a 1; keep a few that cannot decode
                    if ($urandom_range(7) != 0)
                        code[CODE_BITS-1] = 1'b1;
                    queue_frame(code, $urandom_range(7) == 0, $urandom_range(3) == 0,
                                STYLE_ANY);
                end
                else
                begin
                    n = $urandom_range(6, 1);
                    repeat (n)
                        push_run(1'($urandom_range(1)), RUN_LEN_W'($urandom_range(127)),
                                 $urandom_range(5) == 0);
                end
            end
        end

        wait_for_idle();
        $display("Run covered %0d run beats and %0d code beats (%0d valid), %0d register writes",
                 runs_accepted, codes_checked, valid_codes, cfg_writes);
        $display("under six threshold settings, three stall mixes and one long result hold-off");
        if (expected_codes.size() != 0)
            $display("%0d expected code beats never arrived", expected_codes.size());
        if (errors == 0 && expected_codes.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
